### hw/rtl/rbsa_pkg.sv
// rbsa_pkg: shared types and constants of the rounded box shadow alpha core
// no dependencies; used by rbsa_div, rbsa_cell and rounded_box_shadow_alpha_core
package rbsa_pkg;

    // internal coordinate width, wide enough for any box or pixel difference
    localparam int CW    = 20;
    localparam int RAD_W = 7;   // radius and distance
    localparam int SQ_W  = 15;  // sum of two squared distances
    localparam int RT_W  = 8;   // floor square root
    localparam int NUM_W = 15;  // dividend of the alpha step
    localparam int STP_W = 15;  // alpha step

    localparam logic [7:0] KEY_START = 8'd90;
    localparam logic [6:0] AMB_BASE  = 7'd60;

    typedef logic signed [CW-1:0] t_crd;
    typedef logic [RAD_W-1:0]     t_rad;
    typedef logic [STP_W-1:0]     t_step;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_HEIGHT = 3'd3,
        CFG_ELEV   = 3'd4
    } t_cfg_idx;

    // how a pixel sits against one box
    typedef enum logic [1:0] {
        K_ZERO   = 2'd0,  // interior, full start alpha
        K_DIST   = 2'd1,  // side band, straight distance
        K_CORNER = 2'd2,  // corner, distance from square root
        K_FAR    = 2'd3   // beyond the radius, alpha zero
    } t_kind;

    typedef struct packed {
        t_crd x;
        t_crd y;
        t_crd w;
        t_crd h;
        t_rad r;
    } t_box;

    // per box data handed along the square root cells
    typedef struct packed {
        t_kind           kind;
        t_rad            dlen;
        logic [SQ_W-1:0] n;
        logic [RT_W-1:0] root;
    } t_lane;

    typedef struct packed {
        t_lane key;
        t_lane amb;
        logic  last;
    } t_bus;

endpackage

### hw/rtl/rbsa_div.sv
// rbsa_div: iterative restoring divider for the alpha step, one quotient bit a cycle
// depends on rbsa_pkg
module rbsa_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rbsa_pkg::NUM_W-1:0] i_num,
    input  rbsa_pkg::t_rad            i_den,
    output logic                      o_busy,
    output rbsa_pkg::t_step           o_quot
);
    import rbsa_pkg::*;

    logic [NUM_W-1:0] r_q, n_q;
    t_rad             r_rem, n_rem;
    t_rad             r_den;
    logic             r_zero;
    logic [3:0]       r_cnt;
    logic [RAD_W:0]   w_trial;

    // one restoring step
    always_comb begin
        w_trial = {r_rem, r_q[NUM_W-1]};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = RAD_W'(w_trial - {1'b0, r_den});
            n_q   = {r_q[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[RAD_W-1:0];
            n_q   = {r_q[NUM_W-2:0], 1'b0};
        end
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 4'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_zero <= (i_den == '0);
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_zero ? '0 : t_step'(r_q);

endmodule

### hw/rtl/rbsa_cell.sv
// rbsa_cell: one stage of the floor square root chain, settles one root bit per box
// depends on rbsa_pkg
module rbsa_cell #(
    parameter int BIT = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rbsa_pkg::t_bus i_bus,
    output logic           o_ready,
    output logic           o_valid,
    output rbsa_pkg::t_bus o_bus,
    input  logic           i_ready
);
    import rbsa_pkg::*;

    logic r_v;
    t_bus r_bus;
    t_bus w_next;

    function automatic t_lane root_step(input t_lane l);
        logic [RT_W-1:0]   t;
        logic [2*RT_W-1:0] sq;
        t_lane             res;
        res = l;
        t   = l.root | RT_W'(1 << BIT);
        sq  = t * t;
        if (sq <= (2*RT_W)'(l.n))
            res.root = t;
        return res;
    endfunction

    // try this bit on both boxes
    always_comb begin
        w_next      = i_bus;
        w_next.key  = root_step(i_bus.key);
        w_next.amb  = root_step(i_bus.amb);
    end

    assign o_ready = !r_v || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid)
            r_bus <= w_next;
    end

    assign o_valid = r_v;
    assign o_bus   = r_bus;

endmodule

### hw/rtl/rounded_box_shadow_alpha_core.sv
// rounded_box_shadow_alpha_core: shadow alpha of a rounded box, one pixel per beat
// depends on rbsa_pkg, rbsa_div, rbsa_cell
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    tdata {pixel_y, pixel_x}, tlast
//  m_axis    out        m_axis_tvalid / m_axis_tready    tdata shadow_alpha, tlast
//  cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
//  one pixel per cycle while the dividers idle, no write is offered and m_axis
//  does not stall; pipeline of three front stages, eight square root cells,
//  multiply stage and output register; after reset and after each register write
//  the two step dividers run, one quotient bit per cycle; s_axis_tready stays low meanwhile
//  a stall at m_axis fills bubbles first, then holds each stage in place
module rounded_box_shadow_alpha_core #(
    parameter int COORD_BITS    = 16,
    parameter int MAX_ELEVATION = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    input  logic        s_axis_tlast,   // run_end_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] shadow_alpha
    output logic        m_axis_tlast,   // run_end_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rbsa_pkg::*;

    localparam logic [5:0] EMAX = 6'(MAX_ELEVATION);
    localparam t_crd       ONE  = t_crd'(1);

    // configuration registers
    logic [15:0] r_left, r_top;
    logic [11:0] r_width, r_height;
    logic [4:0]  r_elev;
    logic        r_start;

    logic        w_cfg_acc;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_elev   <= '0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[11:0];
                CFG_HEIGHT: r_height <= i_cfg_data[11:0];
                CFG_ELEV:   r_elev   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // dividers start the cycle after any write, and once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
        end else begin
            r_start <= w_cfg_acc;
        end
    end

    function automatic t_crd sext(input logic [15:0] v);
        return t_crd'($signed({{(CW-COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]}));
    endfunction

    function automatic t_crd to_crd(input t_rad v);
        return t_crd'({{(CW-RAD_W){1'b0}}, v});
    endfunction

    // box geometry from the registers
    logic [5:0]  w_e;
    logic [8:0]  w_ra_t;
    logic [9:0]  w_rk_t;
    t_rad        w_ra, w_rk;
    logic [6:0]  w_amb_start;
    t_crd        w_left, w_top, w_wd, w_ht;
    t_box        w_amb, w_key;

    always_comb begin
        w_e         = ({1'b0, r_elev} > EMAX) ? EMAX : {1'b0, r_elev};
        w_ra_t      = {1'b0, w_e, 2'b00} + 9'd12;
        w_rk_t      = {4'b0000, w_e} * 10'd15 + 10'd4;
        w_ra        = {1'b0, w_ra_t[8:3]};
        w_rk        = w_rk_t[9:3];
        w_amb_start = AMB_BASE - {1'b0, w_e};
        w_left      = sext(r_left);
        w_top       = sext(r_top);
        w_wd        = t_crd'({{(CW-12){1'b0}}, r_width});
        w_ht        = t_crd'({{(CW-12){1'b0}}, r_height});
        w_amb.r     = w_ra;
        w_amb.x     = w_left - to_crd(w_ra);
        w_amb.y     = w_top - to_crd(w_ra);
        w_amb.w     = w_wd + to_crd(w_ra) + to_crd(w_ra);
        w_amb.h     = w_ht + to_crd(w_ra) + to_crd(w_ra);
        w_key.r     = w_rk;
        w_key.x     = w_left - to_crd(w_rk >> 1);
        w_key.y     = w_top - to_crd(w_rk >> 1) + t_crd'({{(CW-6){1'b0}}, w_e});
        w_key.w     = w_wd + to_crd(w_rk);
        w_key.h     = w_ht + to_crd(w_rk);
    end

    // alpha steps: 256 * start / radius
    logic  w_kbusy, w_abusy, w_busy;
    t_step w_kstep, w_astep;

    rbsa_div u_key_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   ({KEY_START[6:0], 8'd0}),
        .i_den   (w_rk),
        .o_busy  (w_kbusy),
        .o_quot  (w_kstep)
    );

    rbsa_div u_amb_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   ({w_amb_start, 8'd0}),
        .i_den   (w_ra),
        .o_busy  (w_abusy),
        .o_quot  (w_astep)
    );

    assign w_busy = r_start || w_kbusy || w_abusy;

    // fold into one quarter and classify; corner keeps dx in dlen, dy in n
    function automatic t_lane classify(input t_crd x, input t_crd y, input t_box b);
        t_crd  rc, xf, yf, dx, dy;
        t_lane l;
        rc     = to_crd(b.r);
        xf     = (x >= b.w - rc) ? b.w - x - ONE : x;
        yf     = (y >= b.h - rc) ? b.h - y - ONE : y;
        dx     = rc - xf;
        dy     = rc - yf;
        l.root = '0;
        l.n    = '0;
        l.dlen = '0;
        l.kind = K_ZERO;
        if (xf >= rc) begin
            if (yf < rc) begin
                l.kind = (yf < 0) ? K_FAR : K_DIST;
                l.dlen = dy[RAD_W-1:0];
            end
        end else if (yf >= rc) begin
            l.kind = (xf < 0) ? K_FAR : K_DIST;
            l.dlen = dx[RAD_W-1:0];
        end else if (xf < 0 || yf < 0) begin
            l.kind = K_FAR;
        end else begin
            l.kind = K_CORNER;
            l.dlen = dx[RAD_W-1:0];
            l.n    = SQ_W'(dy[RAD_W-1:0]);
        end
        return l;
    endfunction

    // stage ready chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_cv [0:8];
    logic w_cr [0:8];
    t_bus w_cb [0:8];

    assign w_rdy5 = !r_v5 || m_axis_tready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_cr[0];
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1 && !w_busy && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= s_axis_tvalid && s_axis_tready;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= w_cv[8];
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // stage 1: offsets from each box origin
    t_crd r_kx, r_ky, r_ax, r_ay;
    logic r_l1;
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && s_axis_tvalid && s_axis_tready) begin
            r_kx <= sext(s_axis_tdata[15:0]) - w_key.x;
            r_ky <= sext(s_axis_tdata[31:16]) - w_key.y;
            r_ax <= sext(s_axis_tdata[15:0]) - w_amb.x;
            r_ay <= sext(s_axis_tdata[31:16]) - w_amb.y;
            r_l1 <= s_axis_tlast;
        end
    end

    // stage 2: classification
    t_lane r_k2, r_a2;
    logic  r_l2;
    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_k2 <= classify(r_kx, r_ky, w_key);
            r_a2 <= classify(r_ax, r_ay, w_amb);
            r_l2 <= r_l1;
        end
    end

    // stage 3: sum of squares for corners
    t_lane r_k3, r_a3;
    logic  r_l3;
    function automatic t_lane square(input t_lane l);
        t_lane           res;
        logic [SQ_W-1:0] ex, ey;
        res = l;
        ex  = {{(SQ_W-RAD_W){1'b0}}, l.dlen};
        ey  = {{(SQ_W-RAD_W){1'b0}}, l.n[RAD_W-1:0]};
        res.n = ex * ex + ey * ey;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_k3 <= square(r_k2);
            r_a3 <= square(r_a2);
            r_l3 <= r_l2;
        end
    end

    // square root chain, most significant bit first
    assign w_cv[0]      = r_v3;
    assign w_cb[0].key  = r_k3;
    assign w_cb[0].amb  = r_a3;
    assign w_cb[0].last = r_l3;
    assign w_cr[8]      = w_rdy4;

    for (genvar g = 0; g < RT_W; g++) begin : g_cell
        rbsa_cell #(.BIT(RT_W - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .i_bus   (w_cb[g]),
            .o_ready (w_cr[g]),
            .o_valid (w_cv[g+1]),
            .o_bus   (w_cb[g+1]),
            .i_ready (w_cr[g+1])
        );
    end

    // stage 4: final distance and distance times step
    t_kind r_kk4, r_ak4;
    logic [7:0] r_ks4, r_as4;
    logic r_l4;

    function automatic t_lane settle(input t_lane l, input t_rad r);
        t_lane res;
        res = l;
        if (l.kind == K_CORNER) begin
            if (l.root > {1'b0, r}) res.kind = K_FAR;
            else                    res.dlen = l.root[RAD_W-1:0];
        end
        return res;
    endfunction

    t_lane w_k4, w_a4;
    logic [RAD_W+STP_W-1:0] w_kp, w_ap;
    always_comb begin
        w_k4 = settle(w_cb[8].key, w_key.r);
        w_a4 = settle(w_cb[8].amb, w_amb.r);
        w_kp = w_k4.dlen * w_kstep;
        w_ap = w_a4.dlen * w_astep;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && w_cv[8]) begin
            r_kk4 <= w_k4.kind;
            r_ak4 <= w_a4.kind;
            r_ks4 <= w_kp[15:8];
            r_as4 <= w_ap[15:8];
            r_l4  <= w_cb[8].last;
        end
    end

    // stage 5: per box alpha, sum and saturate into the output register
    function automatic logic [7:0] alpha(input t_kind k, input logic [7:0] st,
                                         input logic [7:0] sub);
        logic [7:0] a;
        unique case (k)
            K_ZERO:  a = st;
            K_FAR:   a = 8'd0;
            default: a = st - sub;
        endcase
        return a;
    endfunction

    logic [8:0] w_sum;
    logic [7:0] r_alpha;
    logic       r_l5;
    assign w_sum = {1'b0, alpha(r_kk4, KEY_START, r_ks4)}
                 + {1'b0, alpha(r_ak4, {1'b0, w_amb_start}, r_as4)};

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r_alpha <= w_sum[8] ? 8'd255 : w_sum[7:0];
            r_l5    <= r_l4;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_alpha;
    assign m_axis_tlast  = r_l5;

    // no pixel enters while the steps are being worked out
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("pixel accepted while dividers busy");

    // a register write restarts the dividers
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_acc |=> r_start)
        else $error("register write did not restart dividers");

    // zero key radius gives a zero key step once settled
    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_busy && w_key.r == '0) |-> (w_kstep == '0))
        else $error("nonzero step for zero radius");

    // a held output is not replaced
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !m_axis_tready) |=> (r_v5 && $stable(r_alpha)))
        else $error("stalled result changed");

endmodule
